// ----- src/fcfs_pkg.sv -----
package fcfs_pkg;

  // Table capacity and derived widths
  localparam int unsigned MaxJobs = 16;
  localparam int unsigned IdxW    = $clog2(MaxJobs);
  localparam int unsigned CntW    = $clog2(MaxJobs + 1);

  // Field widths
  localparam int unsigned IdW    = 8;
  localparam int unsigned ArrW   = 16;
  localparam int unsigned BurstW = 8;
  localparam int unsigned TimeW  = 17;
  localparam int unsigned MetW   = 12;
  localparam int unsigned TotW   = 16;

  localparam logic [MetW-1:0] MetSat = {MetW{1'b1}};
  localparam logic [TotW-1:0] TotSat = {TotW{1'b1}};

  // One stored job record
  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [ArrW-1:0]   arrival;
    logic [BurstW-1:0] burst;
  } job_t;

endpackage

// ----- src/fcfs_schedule_timing.sv -----
// Loading: one job record is taken per cycle; records produce no result.
// Scheduling starts on the record flagged last and the input stalls until it ends.
// Each result comes from a scan of the job table
// (one read per cycle on its single port) that picks the earliest job, then
// start, completion, turnaround and waiting are worked out over four steps.
// Reset (asynchronous, active low) empties the set; table contents are not cleared.
module fcfs_schedule_timing (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [fcfs_pkg::IdW-1:0]   job_id_i,
  input  logic [fcfs_pkg::ArrW-1:0]  arrival_i,
  input  logic [fcfs_pkg::BurstW-1:0] burst_i,
  input  logic                       last_job_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [fcfs_pkg::IdW-1:0]   out_job_id_o,
  output logic [fcfs_pkg::TimeW-1:0] start_time_o,
  output logic [fcfs_pkg::TimeW-1:0] completion_o,
  output logic [fcfs_pkg::MetW-1:0]  turnaround_o,
  output logic [fcfs_pkg::MetW-1:0]  waiting_o,
  output logic [fcfs_pkg::TotW-1:0]  total_waiting_o,
  output logic [fcfs_pkg::TotW-1:0]  total_turnaround_o,
  output logic                       overflow_o,
  output logic                       last_result_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_DONE  = 3'd3;
  localparam logic [2:0] S_TA    = 3'd4;
  localparam logic [2:0] S_WT    = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  localparam int unsigned IdxW  = fcfs_pkg::IdxW;
  localparam int unsigned CntW  = fcfs_pkg::CntW;
  localparam int unsigned TimeW = fcfs_pkg::TimeW;
  localparam int unsigned MetW  = fcfs_pkg::MetW;
  localparam int unsigned TotW  = fcfs_pkg::TotW;
  localparam int unsigned BurstW = fcfs_pkg::BurstW;

  // Control state
  logic [2:0]                  state_q, state_d;
  logic [CntW-1:0]             job_count_q;
  logic                        dropped_q;
  logic [TimeW-1:0]            clock_q;
  logic [fcfs_pkg::MaxJobs-1:0] taken_q;
  logic [IdxW-1:0]             scan_addr_q;
  logic                        scan_issue_q;
  logic                        rd_vld_q;
  logic [IdxW-1:0]             rd_idx_q;
  logic                        best_vld_q;
  logic [IdxW-1:0]             best_idx_q;
  logic [IdxW-1:0]             res_cnt_q;
  logic [TotW-1:0]             tot_w_q, tot_t_q;
  logic                        out_valid_q;

  // Payload
  fcfs_pkg::job_t              table_q [fcfs_pkg::MaxJobs];
  fcfs_pkg::job_t              rd_q;
  fcfs_pkg::job_t              best_q;
  logic [TimeW-1:0]            start_q;
  logic [TimeW:0]              done_q;
  logic [MetW-1:0]             ta_q, wt_q;

  logic [fcfs_pkg::IdW-1:0]    o_id_q;
  logic [TimeW-1:0]            o_start_q, o_done_q;
  logic [MetW-1:0]             o_ta_q, o_wt_q;
  logic [TotW-1:0]             o_totw_q, o_tott_q;
  logic                        o_ovf_q, o_last_q;

  logic                        in_xfer, out_free, room, emit, last_res, better;
  logic [CntW-1:0]             cnt_m1;
  logic [IdxW-1:0]             last_idx;
  logic [TimeW:0]              ta_diff;
  logic [TotW:0]               sum_w, sum_t;
  logic [TotW-1:0]             tot_w_d, tot_t_d;
  fcfs_pkg::job_t              wr_rec;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign room       = (job_count_q < CntW'(fcfs_pkg::MaxJobs));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit       = (state_q == S_EMIT) && out_free;
  assign cnt_m1     = job_count_q - CntW'(1);
  assign last_idx   = cnt_m1[IdxW-1:0];
  assign last_res   = (res_cnt_q == last_idx);

  // Zero burst counts as one tick
  always_comb begin
    wr_rec.id      = job_id_i;
    wr_rec.arrival = arrival_i;
    wr_rec.burst   = (burst_i == '0) ? BurstW'(1) : burst_i;
  end

  // Candidate beats the current best on strictly earlier arrival
  assign better = rd_vld_q && !taken_q[rd_idx_q] &&
                  (!best_vld_q || (rd_q.arrival < best_q.arrival));

  // Shared arithmetic results
  assign ta_diff = done_q - {2'b0, best_q.arrival};
  assign sum_w   = {1'b0, tot_w_q} + {{(TotW + 1 - MetW){1'b0}}, wt_q};
  assign sum_t   = {1'b0, tot_t_q} + {{(TotW + 1 - MetW){1'b0}}, ta_q};
  assign tot_w_d = sum_w[TotW] ? fcfs_pkg::TotSat : sum_w[TotW-1:0];
  assign tot_t_d = sum_t[TotW] ? fcfs_pkg::TotSat : sum_t[TotW-1:0];

  // Job table: one write port on load, one registered read port for the scan
  always_ff @(posedge clk_i) begin
    if (in_xfer && room) begin
      table_q[job_count_q[IdxW-1:0]] <= wr_rec;
    end
    rd_q <= table_q[scan_addr_q];
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_xfer && last_job_i) state_d = S_SCAN;
      S_SCAN:  if (rd_vld_q && (rd_idx_q == last_idx)) state_d = S_START;
      S_START: state_d = S_DONE;
      S_DONE:  state_d = S_TA;
      S_TA:    state_d = S_WT;
      S_WT:    state_d = S_EMIT;
      S_EMIT:  if (out_free) state_d = last_res ? S_IDLE : S_SCAN;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      job_count_q  <= '0;
      dropped_q    <= 1'b0;
      clock_q      <= '0;
      taken_q      <= '0;
      scan_addr_q  <= '0;
      scan_issue_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      rd_idx_q     <= '0;
      best_vld_q   <= 1'b0;
      best_idx_q   <= '0;
      res_cnt_q    <= '0;
      tot_w_q      <= '0;
      tot_t_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == S_SCAN) && scan_issue_q;
      rd_idx_q <= scan_addr_q;

      // Load a record or note the drop
      if (in_xfer) begin
        if (room) job_count_q <= job_count_q + CntW'(1);
        else      dropped_q   <= 1'b1;
        if (last_job_i) begin
          taken_q      <= '0;
          clock_q      <= '0;
          tot_w_q      <= '0;
          tot_t_q      <= '0;
          res_cnt_q    <= '0;
          scan_addr_q  <= '0;
          scan_issue_q <= 1'b1;
          best_vld_q   <= 1'b0;
        end
      end

      // Advance the scan address
      if ((state_q == S_SCAN) && scan_issue_q) begin
        if (scan_addr_q == last_idx) scan_issue_q <= 1'b0;
        else                         scan_addr_q  <= scan_addr_q + IdxW'(1);
      end

      if (better) begin
        best_vld_q <= 1'b1;
        best_idx_q <= rd_idx_q;
      end

      // Retire the chosen job
      if (emit) begin
        taken_q[best_idx_q] <= 1'b1;
        clock_q             <= done_q[TimeW-1:0];
        tot_w_q             <= tot_w_d;
        tot_t_q             <= tot_t_d;
        if (last_res) begin
          job_count_q <= '0;
          dropped_q   <= 1'b0;
        end else begin
          res_cnt_q    <= res_cnt_q + IdxW'(1);
          scan_addr_q  <= '0;
          scan_issue_q <= 1'b1;
          best_vld_q   <= 1'b0;
        end
      end

      // Hold the result until its transfer
      if (emit)              out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (better) best_q <= rd_q;

    case (state_q)
      S_START: start_q <= (clock_q > {1'b0, best_q.arrival}) ?
                          clock_q : {1'b0, best_q.arrival};
      S_DONE:  done_q  <= {1'b0, start_q} + {{(TimeW + 1 - BurstW){1'b0}}, best_q.burst};
      S_TA:    ta_q    <= (ta_diff > {{(TimeW + 1 - MetW){1'b0}}, fcfs_pkg::MetSat}) ?
                          fcfs_pkg::MetSat : ta_diff[MetW-1:0];
      S_WT:    wt_q    <= (ta_q >= {{(MetW - BurstW){1'b0}}, best_q.burst}) ?
                          (ta_q - {{(MetW - BurstW){1'b0}}, best_q.burst}) : '0;
      default: ;
    endcase

    if (emit) begin
      o_id_q    <= best_q.id;
      o_start_q <= start_q;
      o_done_q  <= done_q[TimeW-1:0];
      o_ta_q    <= ta_q;
      o_wt_q    <= wt_q;
      o_totw_q  <= last_res ? tot_w_d : '0;
      o_tott_q  <= last_res ? tot_t_d : '0;
      o_ovf_q   <= dropped_q;
      o_last_q  <= last_res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_job_id_o       = o_id_q;
  assign start_time_o       = o_start_q;
  assign completion_o       = o_done_q;
  assign turnaround_o       = o_ta_q;
  assign waiting_o          = o_wt_q;
  assign total_waiting_o    = o_totw_q;
  assign total_turnaround_o = o_tott_q;
  assign overflow_o         = o_ovf_q;
  assign last_result_o      = o_last_q;

endmodule
